>>> hw/rtl/bitmask_overlap_collision_assert.svh
// Assertion macros for the collision block
`ifndef BITMASK_OVERLAP_COLLISION_ASSERT_SVH
`define BITMASK_OVERLAP_COLLISION_ASSERT_SVH

// same-cycle implication
`define BOC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BOC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/boc_pkg.sv
// ----------------------------------------------------------------------------
// boc_pkg
// Shared types and constants for the bitmask overlap collision block.
// ----------------------------------------------------------------------------
`default_nettype none

package boc_pkg;

    localparam int MASK_WORDS  = 65536;
    localparam int ADDR_W      = $clog2(MASK_WORDS);
    localparam int WORD_BITS   = 32;
    localparam int BITPOS_W    = $clog2(WORD_BITS);
    localparam int MAX_SPAN    = 1024;
    localparam int SPAN_W      = 11;
    localparam int COORD_W     = 16;
    localparam int EXT_W       = COORD_W + 2;
    localparam int PITCH_W     = 6;
    localparam int CHUNK_W     = SPAN_W - BITPOS_W + 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int CFG_IDX_W   = 2;

    localparam logic [PITCH_W-1:0] PITCH_RESET = PITCH_W'(33);

    typedef enum logic [1:0] {
        CMD_WRITE_A = 2'd0,
        CMD_WRITE_B = 2'd1,
        CMD_TEST    = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PITCH_A = 2'd0,
        REG_PITCH_B = 2'd1,
        REG_SPARE_2 = 2'd2,
        REG_SPARE_3 = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        JOB_WRITE_A = 2'd0,
        JOB_WRITE_B = 2'd1,
        JOB_TEST    = 2'd2,
        JOB_MISS    = 2'd3
    } job_kind_t;

    typedef struct packed {
        job_kind_t              kind;
        logic [ADDR_W-1:0]      addr;
        logic [WORD_BITS-1:0]   data;
        logic [SPAN_W-1:0]      xa;
        logic [SPAN_W-1:0]      ya;
        logic [SPAN_W-1:0]      xb;
        logic [SPAN_W-1:0]      yb;
        logic [SPAN_W-1:0]      ow;
        logic [SPAN_W-1:0]      oh;
        logic [CHUNK_W-1:0]     chunks;
    } job_t;

endpackage

`default_nettype wire

>>> hw/rtl/boc_ram.sv
// ----------------------------------------------------------------------------
// boc_ram
// Generic single-port RAM, one write or read a cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module boc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/boc_front.sv
// ----------------------------------------------------------------------------
// boc_front
// Classifies requests: writes pass through, tests get their overlap region.
// ----------------------------------------------------------------------------
`default_nettype none

module boc_front (
    input  wire logic                          cmd_valid,
    output logic                               cmd_ready,
    input  wire logic [1:0]                    command,
    input  wire logic [boc_pkg::ADDR_W-1:0]    word_index,
    input  wire logic [boc_pkg::WORD_BITS-1:0] word_value,
    input  wire logic [boc_pkg::COORD_W-1:0]   left_a,
    input  wire logic [boc_pkg::COORD_W-1:0]   top_a,
    input  wire logic [boc_pkg::SPAN_W-1:0]    span_x_a,
    input  wire logic [boc_pkg::SPAN_W-1:0]    span_y_a,
    input  wire logic [boc_pkg::COORD_W-1:0]   left_b,
    input  wire logic [boc_pkg::COORD_W-1:0]   top_b,
    input  wire logic [boc_pkg::SPAN_W-1:0]    span_x_b,
    input  wire logic [boc_pkg::SPAN_W-1:0]    span_y_b,
    input  wire logic                          q_full,
    output logic                               q_push,
    output boc_pkg::job_t                      q_job
);

    import boc_pkg::*;

    logic signed [EXT_W-1:0] lax, lbx, tay, tby, wax, wbx, hay, hby;
    logic signed [EXT_W-1:0] eax, ebx, eay, eby;
    logic signed [EXT_W-1:0] ox, oy, offx, offy;
    logic                    a_left, a_top, disjoint;

    always_comb
    begin
        lax = $signed({{2{left_a[COORD_W-1]}}, left_a});
        lbx = $signed({{2{left_b[COORD_W-1]}}, left_b});
        tay = $signed({{2{top_a[COORD_W-1]}}, top_a});
        tby = $signed({{2{top_b[COORD_W-1]}}, top_b});
        wax = $signed({(EXT_W-SPAN_W)'(0), span_x_a});
        wbx = $signed({(EXT_W-SPAN_W)'(0), span_x_b});
        hay = $signed({(EXT_W-SPAN_W)'(0), span_y_a});
        hby = $signed({(EXT_W-SPAN_W)'(0), span_y_b});
        eax = lax + wax;
        ebx = lbx + wbx;
        eay = tay + hay;
        eby = tby + hby;
        disjoint = (lax >= ebx) || (lbx >= eax) || (tay >= eby) || (tby >= eay);
        a_left = (lax <= lbx);
        a_top  = (tay <= tby);
        offx = a_left ? (lbx - lax) : (lax - lbx);
        offy = a_top ? (tby - tay) : (tay - tby);
        if (a_left)
        begin
            ox = ((eax - lbx) < wbx) ? (eax - lbx) : wbx;
        end
        else
        begin
            ox = ((ebx - lax) < wax) ? (ebx - lax) : wax;
        end
        if (a_top)
        begin
            oy = ((eay - tby) < hby) ? (eay - tby) : hby;
        end
        else
        begin
            oy = ((eby - tay) < hay) ? (eby - tay) : hay;
        end

        q_job.addr   = word_index;
        q_job.data   = word_value;
        q_job.xa     = a_left ? offx[SPAN_W-1:0] : '0;
        q_job.xb     = a_left ? '0 : offx[SPAN_W-1:0];
        q_job.ya     = a_top ? offy[SPAN_W-1:0] : '0;
        q_job.yb     = a_top ? '0 : offy[SPAN_W-1:0];
        q_job.ow     = ox[SPAN_W-1:0];
        q_job.oh     = oy[SPAN_W-1:0];
        q_job.chunks = CHUNK_W'(({1'b0, ox[SPAN_W-1:0]} + (SPAN_W+1)'(WORD_BITS - 1))
                                >> BITPOS_W);

        case (cmd_t'(command))
            CMD_WRITE_A: q_job.kind = JOB_WRITE_A;
            CMD_WRITE_B: q_job.kind = JOB_WRITE_B;
            CMD_TEST:
            begin
                if (disjoint || (ox[SPAN_W-1:0] == '0) || (oy[SPAN_W-1:0] == '0))
                begin
                    q_job.kind = JOB_MISS;
                end
                else
                begin
                    q_job.kind = JOB_TEST;
                end
            end
            default: q_job.kind = JOB_MISS;
        endcase

        cmd_ready = !q_full;
        q_push    = cmd_valid && !q_full && (cmd_t'(command) != CMD_NONE);
    end

endmodule

`default_nettype wire

>>> hw/rtl/boc_queue.sv
// ----------------------------------------------------------------------------
// boc_queue
// Small job queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module boc_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire boc_pkg::job_t push_job,
    input  wire logic          pop,
    output boc_pkg::job_t      head_job,
    output logic               full,
    output logic               empty
);

    import boc_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    job_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   count_reg, count_next;

    assign full     = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/boc_back.sv
// ----------------------------------------------------------------------------
// boc_back
// Executes jobs: mask writes, and the chunk walk over the overlap region.
// ----------------------------------------------------------------------------
`default_nettype none

module boc_back (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    input  wire logic [boc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [boc_pkg::PITCH_W-1:0]    cfg_data,
    input  wire logic                           q_empty,
    input  wire boc_pkg::job_t                  q_job,
    output logic                                q_pop,
    output logic                                res_valid,
    input  wire logic                           res_ready,
    output logic                                hit
);

    import boc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SETUP,
        S_ISSUE,
        S_WAIT
    } state_t;

    state_t                 state_reg, state_next;
    logic [PITCH_W-1:0]     pitch_a_reg, pitch_b_reg;
    logic                   res_valid_reg, res_valid_next;
    logic                   hit_reg, hit_next;
    logic                   pvld_reg, pvld_next;
    logic [CHUNK_W-1:0]     pk_reg, pk_next;
    logic [CHUNK_W-1:0]     k_reg, k_next;
    logic [CHUNK_W-1:0]     n_reg, n_next;
    logic [SPAN_W-1:0]      j_reg, j_next;
    logic [SPAN_W-1:0]      h_reg, h_next;
    logic [SPAN_W-1:0]      w_reg, w_next;
    logic [SPAN_W-1:0]      rem_reg, rem_next;
    logic [SPAN_W-1:0]      xa_reg, xa_next, ya_reg, ya_next;
    logic [SPAN_W-1:0]      xb_reg, xb_next, yb_reg, yb_next;
    logic [ADDR_W-1:0]      rowa_reg, rowa_next, rowb_reg, rowb_next;
    logic [WORD_BITS-1:0]   preva_reg, preva_next, prevb_reg, prevb_next;

    logic                   we_a, we_b;
    logic [ADDR_W-1:0]      addr_a, addr_b;
    logic [WORD_BITS-1:0]   rd_a, rd_b;
    logic [WORD_BITS-1:0]   chunk_a, chunk_b, keep;
    logic                   eval, last, hit_now;

    boc_ram #(.WIDTH(WORD_BITS), .DEPTH(MASK_WORDS)) u_ram_a (
        .clk   (clk),
        .we    (we_a),
        .addr  (addr_a),
        .wdata (q_job.data),
        .rdata (rd_a)
    );

    boc_ram #(.WIDTH(WORD_BITS), .DEPTH(MASK_WORDS)) u_ram_b (
        .clk   (clk),
        .we    (we_b),
        .addr  (addr_b),
        .wdata (q_job.data),
        .rdata (rd_b)
    );

    assign res_valid = res_valid_reg;
    assign hit       = hit_reg;

    always_comb
    begin
        chunk_a = WORD_BITS'({rd_a, preva_reg} >> xa_reg[BITPOS_W-1:0]);
        chunk_b = WORD_BITS'({rd_b, prevb_reg} >> xb_reg[BITPOS_W-1:0]);
        keep    = (rem_reg >= SPAN_W'(WORD_BITS)) ? '1
                : ((WORD_BITS'(1) << rem_reg[BITPOS_W-1:0]) - 1'b1);
        eval    = pvld_reg && (pk_reg != '0);
        last    = pvld_reg && (pk_reg == n_reg);
        hit_now = eval && ((chunk_a & chunk_b & keep) != '0);

        state_next     = state_reg;
        res_valid_next = res_valid_reg && !res_ready;
        hit_next       = hit_reg;
        pvld_next      = 1'b0;
        pk_next        = pk_reg;
        k_next         = k_reg;
        n_next         = n_reg;
        j_next         = j_reg;
        h_next         = h_reg;
        w_next         = w_reg;
        rem_next       = rem_reg;
        xa_next        = xa_reg;
        ya_next        = ya_reg;
        xb_next        = xb_reg;
        yb_next        = yb_reg;
        rowa_next      = rowa_reg;
        rowb_next      = rowb_reg;
        preva_next     = preva_reg;
        prevb_next     = prevb_reg;
        q_pop          = 1'b0;
        we_a           = 1'b0;
        we_b           = 1'b0;
        addr_a         = rowa_reg + ADDR_W'(k_reg);
        addr_b         = rowb_reg + ADDR_W'(k_reg);

        case (state_reg)
            S_IDLE:
            begin
                addr_a = q_job.addr;
                addr_b = q_job.addr;
                if (!q_empty && !res_valid_reg)
                begin
                    q_pop = 1'b1;
                    case (q_job.kind)
                        JOB_WRITE_A: we_a = 1'b1;
                        JOB_WRITE_B: we_b = 1'b1;
                        JOB_TEST:
                        begin
                            xa_next    = q_job.xa;
                            ya_next    = q_job.ya;
                            xb_next    = q_job.xb;
                            yb_next    = q_job.yb;
                            w_next     = q_job.ow;
                            h_next     = q_job.oh;
                            n_next     = q_job.chunks;
                            state_next = S_SETUP;
                        end
                        default:
                        begin
                            res_valid_next = 1'b1;
                            hit_next       = 1'b0;
                        end
                    endcase
                end
            end
            S_SETUP:
            begin
                rowa_next  = ADDR_W'(ya_reg * pitch_a_reg) + ADDR_W'(xa_reg >> BITPOS_W);
                rowb_next  = ADDR_W'(yb_reg * pitch_b_reg) + ADDR_W'(xb_reg >> BITPOS_W);
                j_next     = '0;
                k_next     = '0;
                rem_next   = w_reg;
                state_next = S_ISSUE;
            end
            S_ISSUE:
            begin
                pvld_next = 1'b1;
                pk_next   = k_reg;
                if (k_reg == n_reg)
                begin
                    state_next = S_WAIT;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            S_WAIT:
            begin
                if (last && !hit_now)
                begin
                    if (j_reg + 1'b1 == h_reg)
                    begin
                        res_valid_next = 1'b1;
                        hit_next       = 1'b0;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        j_next     = j_reg + 1'b1;
                        k_next     = '0;
                        rem_next   = w_reg;
                        rowa_next  = rowa_reg + ADDR_W'(pitch_a_reg);
                        rowb_next  = rowb_reg + ADDR_W'(pitch_b_reg);
                        state_next = S_ISSUE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase

        if ((state_reg == S_ISSUE) || (state_reg == S_WAIT))
        begin
            if (pvld_reg)
            begin
                preva_next = rd_a;
                prevb_next = rd_b;
            end
            if (eval && !last)
            begin
                rem_next = rem_reg - SPAN_W'(WORD_BITS);
            end
            if (hit_now)
            begin
                res_valid_next = 1'b1;
                hit_next       = 1'b1;
                pvld_next      = 1'b0;
                state_next     = S_IDLE;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pk_reg    <= pk_next;
        k_reg     <= k_next;
        n_reg     <= n_next;
        j_reg     <= j_next;
        h_reg     <= h_next;
        w_reg     <= w_next;
        rem_reg   <= rem_next;
        xa_reg    <= xa_next;
        ya_reg    <= ya_next;
        xb_reg    <= xb_next;
        yb_reg    <= yb_next;
        rowa_reg  <= rowa_next;
        rowb_reg  <= rowb_next;
        preva_reg <= preva_next;
        prevb_reg <= prevb_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            pvld_reg      <= 1'b0;
            pitch_a_reg   <= PITCH_RESET;
            pitch_b_reg   <= PITCH_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            hit_reg       <= hit_next;
            pvld_reg      <= pvld_next;
            if (cfg_valid && (cfg_reg_t'(cfg_index) == REG_PITCH_A))
            begin
                pitch_a_reg <= cfg_data;
            end
            if (cfg_valid && (cfg_reg_t'(cfg_index) == REG_PITCH_B))
            begin
                pitch_b_reg <= cfg_data;
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/bitmask_overlap_collision.sv
// A write is stored in its mask RAM when the back end pops it. With the walker free,
// a missing test raises its result from the idle state without a walk, and an
// overlapping one walks each overlap row, chunks = ceil(overlap width / 32) per row,
// reading both mask RAM ports one word a cycle. A hit ends the walk early.
// One write a cycle when idle with no result held; up to four requests queue ahead.
// Reset clears control state and sets both pitches to 33; mask contents are kept.
// ----------------------------------------------------------------------------
// bitmask_overlap_collision
// Pixel-exact collision test between two stored one-bit masks.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmask_overlap_collision (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [boc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [boc_pkg::PITCH_W-1:0]    cfg_data,
    input  wire logic                           cmd_valid,
    output logic                                cmd_ready,
    input  wire logic [1:0]                     command,
    input  wire logic [boc_pkg::ADDR_W-1:0]     word_index,
    input  wire logic [boc_pkg::WORD_BITS-1:0]  word_value,
    input  wire logic [boc_pkg::COORD_W-1:0]    left_a,
    input  wire logic [boc_pkg::COORD_W-1:0]    top_a,
    input  wire logic [boc_pkg::SPAN_W-1:0]     span_x_a,
    input  wire logic [boc_pkg::SPAN_W-1:0]     span_y_a,
    input  wire logic [boc_pkg::COORD_W-1:0]    left_b,
    input  wire logic [boc_pkg::COORD_W-1:0]    top_b,
    input  wire logic [boc_pkg::SPAN_W-1:0]     span_x_b,
    input  wire logic [boc_pkg::SPAN_W-1:0]     span_y_b,
    output logic                                res_valid,
    input  wire logic                           res_ready,
    output logic                                hit
);

    import boc_pkg::*;

    job_t push_job, head_job;
    logic q_push, q_pop, q_full, q_empty;

    assign cfg_ready = 1'b1;

    boc_front u_front (
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .command    (command),
        .word_index (word_index),
        .word_value (word_value),
        .left_a     (left_a),
        .top_a      (top_a),
        .span_x_a   (span_x_a),
        .span_y_a   (span_y_a),
        .left_b     (left_b),
        .top_b      (top_b),
        .span_x_b   (span_x_b),
        .span_y_b   (span_y_b),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_job      (push_job)
    );

    boc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head_job (head_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    boc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_empty   (q_empty),
        .q_job     (head_job),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .hit       (hit)
    );

endmodule

`default_nettype wire

>>> hw/rtl/boc_checker.sv
// ----------------------------------------------------------------------------
// boc_checker
// Port-level checks: results only for outstanding tests, bounded backlog.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bitmask_overlap_collision_assert.svh"

module boc_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       cmd_valid,
    input wire logic       cmd_ready,
    input wire logic [1:0] command,
    input wire logic       res_valid,
    input wire logic       res_ready,
    input wire logic       hit
);

    import boc_pkg::*;

    logic [3:0] pending_reg;
    logic       test_acc, res_acc;

    assign test_acc = cmd_valid && cmd_ready && (cmd_t'(command) == CMD_TEST);
    assign res_acc  = res_valid && res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + 4'(test_acc) - 4'(res_acc);
        end
    end

    `BOC_ASSERT_NOW(a_res_has_test, res_valid, pending_reg != 4'd0, "result without a test")
    `BOC_ASSERT_NOW(a_backlog, 1'b1, pending_reg <= 4'd6, "test backlog too deep")
    `BOC_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(hit),
                     "result dropped while stalled")

endmodule

bind bitmask_overlap_collision boc_checker u_boc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .command   (command),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .hit       (hit)
);

`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bitmask overlap collision block. Before each
// test request, every mask word its walk may read that has not been written
// yet is written first, so no test reads an unwritten word. A short table of
// directed requests comes first, then random writes and placed rectangle
// pairs under several pitch settings and idling patterns. Each test request
// without a given result is predicted from a local copy of the masks and
// pitches, and each returned hit is compared in order.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import boc_pkg::*;

    typedef struct {
        cmd_t                   cmd;
        logic [ADDR_W-1:0]      idx;
        logic [WORD_BITS-1:0]   val;
        logic [COORD_W-1:0]     la, ta, lb, tb;
        logic [SPAN_W-1:0]      wa, ha, wb, hb;
        int                     known;
    } request_t;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int N_PHASES       = 8;
    localparam int PER_PHASE      = 64;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [PITCH_W-1:0]     cfg_data;
    logic                   cmd_valid;
    logic                   cmd_ready;
    logic [1:0]             command;
    logic [ADDR_W-1:0]      word_index;
    logic [WORD_BITS-1:0]   word_value;
    logic [COORD_W-1:0]     left_a, top_a, left_b, top_b;
    logic [SPAN_W-1:0]      span_x_a, span_y_a, span_x_b, span_y_b;
    logic                   res_valid;
    logic                   res_ready;
    logic                   hit;

    logic [WORD_BITS-1:0]   mask_a_image [MASK_WORDS];
    logic [WORD_BITS-1:0]   mask_b_image [MASK_WORDS];
    bit                     written_a [MASK_WORDS];
    bit                     written_b [MASK_WORDS];
    int                     pitch_a;
    int                     pitch_b;
    bit                     hit_expected [$];
    int                     fails;
    int                     sent;
    int                     send_idle;
    int                     recv_stall;
    int                     quiet_cycles;

    bitmask_overlap_collision u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .command    (command),
        .word_index (word_index),
        .word_value (word_value),
        .left_a     (left_a),
        .top_a      (top_a),
        .span_x_a   (span_x_a),
        .span_y_a   (span_y_a),
        .left_b     (left_b),
        .top_b      (top_b),
        .span_x_b   (span_x_b),
        .span_y_b   (span_y_b),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .hit        (hit)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic logic [31:0] chunk_at(bit use_b, longint addr, int bp);
        logic [31:0] lo;
        logic [31:0] hi;
        lo = use_b ? mask_b_image[addr[15:0]] : mask_a_image[addr[15:0]];
        if (bp == 0)
            return lo;
        hi = use_b ? mask_b_image[16'(addr + 1)] : mask_a_image[16'(addr + 1)];
        return (lo >> bp) | (hi << (32 - bp));
    endfunction

    function automatic bit predict_hit(request_t r);
        int     x, y, w, h, x2, y2, w2, h2;
        int     xa, ya, xb, yb, ow, oh, rem, done;
        longint rowa, rowb, k;
        logic [31:0] keep;
        x  = int'($signed(r.la));
        y  = int'($signed(r.ta));
        x2 = int'($signed(r.lb));
        y2 = int'($signed(r.tb));
        w  = int'(r.wa);
        h  = int'(r.ha);
        w2 = int'(r.wb);
        h2 = int'(r.hb);
        if (x >= x2 + w2 || x2 >= x + w || y >= y2 + h2 || y2 >= y + h)
            return 1'b0;
        if (x <= x2)
        begin
            xa = x2 - x;
            xb = 0;
            ow = (x + w - x2 < w2) ? x + w - x2 : w2;
        end
        else
        begin
            xa = 0;
            xb = x - x2;
            ow = (x2 + w2 - x < w) ? x2 + w2 - x : w;
        end
        if (y <= y2)
        begin
            ya = y2 - y;
            yb = 0;
            oh = (y + h - y2 < h2) ? y + h - y2 : h2;
        end
        else
        begin
            ya = 0;
            yb = y - y2;
            oh = (y2 + h2 - y < h) ? y2 + h2 - y : h;
        end
        for (int j = 0; j < oh; j++)
        begin
            rowa = longint'(ya + j) * pitch_a + (xa >> 5);
            rowb = longint'(yb + j) * pitch_b + (xb >> 5);
            done = 0;
            k = 0;
            while (done < ow)
            begin
                rem  = ow - done;
                keep = (rem >= 32) ? 32'hFFFF_FFFF : (32'd1 << rem) - 32'd1;
                if ((chunk_at(1'b0, rowa + k, xa & 31) &
                     chunk_at(1'b1, rowb + k, xb & 31) & keep) != 0)
                    return 1'b1;
                done += (rem >= 32) ? 32 : rem;
                k++;
            end
        end
        return 1'b0;
    endfunction

    // overlap region of a test, 0 when it is empty
    function automatic bit overlap_of(request_t r, output int xa, output int ya,
                                      output int xb, output int yb,
                                      output int ow, output int oh);
        int x, y, w, h, x2, y2, w2, h2;
        xa = 0;
        ya = 0;
        xb = 0;
        yb = 0;
        ow = 0;
        oh = 0;
        x  = int'($signed(r.la));
        y  = int'($signed(r.ta));
        x2 = int'($signed(r.lb));
        y2 = int'($signed(r.tb));
        w  = int'(r.wa);
        h  = int'(r.ha);
        w2 = int'(r.wb);
        h2 = int'(r.hb);
        if (x >= x2 + w2 || x2 >= x + w || y >= y2 + h2 || y2 >= y + h)
            return 1'b0;
        if (x <= x2)
        begin
            xa = x2 - x;
            ow = (x + w - x2 < w2) ? x + w - x2 : w2;
        end
        else
        begin
            xb = x - x2;
            ow = (x2 + w2 - x < w) ? x2 + w2 - x : w;
        end
        if (y <= y2)
        begin
            ya = y2 - y;
            oh = (y + h - y2 < h2) ? y + h - y2 : h2;
        end
        else
        begin
            yb = y - y2;
            oh = (y2 + h2 - y < h) ? y2 + h2 - y : h;
        end
        return (ow > 0) && (oh > 0);
    endfunction

    function automatic logic [31:0] sparse_word();
        return ($urandom_range(0, 2) == 0) ? ($urandom & $urandom) : 32'd0;
    endfunction

    // drive one request, wait for acceptance, update the local image
    task automatic send_request(request_t r);
        int gap;
        if (send_idle > 0 && $urandom_range(0, 99) < send_idle)
        begin
            gap = $urandom_range(1, 4);
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid  <= 1'b1;
        command    <= r.cmd;
        word_index <= r.idx;
        word_value <= r.val;
        left_a     <= r.la;
        top_a      <= r.ta;
        span_x_a   <= r.wa;
        span_y_a   <= r.ha;
        left_b     <= r.lb;
        top_b      <= r.tb;
        span_x_b   <= r.wb;
        span_y_b   <= r.hb;
        do
            @(posedge clk);
        while (!cmd_ready);
        sent++;
        case (r.cmd)
            CMD_WRITE_A:
            begin
                mask_a_image[r.idx] = r.val;
                written_a[r.idx]    = 1'b1;
            end
            CMD_WRITE_B:
            begin
                mask_b_image[r.idx] = r.val;
                written_b[r.idx]    = 1'b1;
            end
            CMD_TEST:
            begin
                if (r.known >= 0)
                    hit_expected.push_back(r.known[0]);
                else
                    hit_expected.push_back(predict_hit(r));
            end
            default: ;
        endcase
    endtask

    // write every still unwritten word that the walk of a test may read
    task automatic cover_reads(request_t r);
        int                xa, ya, xb, yb, ow, oh, chunks;
        logic [ADDR_W-1:0] adr;
        request_t          f;
        if (r.cmd != CMD_TEST || !overlap_of(r, xa, ya, xb, yb, ow, oh))
            return;
        chunks = (ow + 31) >> 5;
        for (int j = 0; j < oh; j++)
        begin
            for (int k = 0; k <= chunks; k++)
            begin
                adr = ADDR_W'(longint'(ya + j) * pitch_a + (xa >> 5) + k);
                if (!written_a[adr])
                begin
                    f     = blank_request(CMD_WRITE_A);
                    f.idx = adr;
                    f.val = sparse_word();
                    send_request(f);
                end
                adr = ADDR_W'(longint'(yb + j) * pitch_b + (xb >> 5) + k);
                if (!written_b[adr])
                begin
                    f     = blank_request(CMD_WRITE_B);
                    f.idx = adr;
                    f.val = sparse_word();
                    send_request(f);
                end
            end
        end
    endtask

    task automatic drain_results();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (hit_expected.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_pitch(cfg_reg_t which, logic [PITCH_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= which;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (which == REG_PITCH_A)
            pitch_a = int'(value);
        else
            pitch_b = int'(value);
        @(posedge clk);
    endtask

    function automatic request_t blank_request(cmd_t c);
        request_t r;
        r.cmd   = c;
        r.idx   = '0;
        r.val   = '0;
        r.la    = '0;
        r.ta    = '0;
        r.lb    = '0;
        r.tb    = '0;
        r.wa    = '0;
        r.ha    = '0;
        r.wb    = '0;
        r.hb    = '0;
        r.known = -1;
        return r;
    endfunction

    function automatic request_t test_request(int la, int ta, int wa, int ha,
                                              int lb, int tb, int wb, int hb,
                                              int known);
        request_t r;
        r       = blank_request(CMD_TEST);
        r.la    = 16'(la);
        r.ta    = 16'(ta);
        r.wa    = 11'(wa);
        r.ha    = 11'(ha);
        r.lb    = 16'(lb);
        r.tb    = 16'(tb);
        r.wb    = 11'(wb);
        r.hb    = 11'(hb);
        r.known = known;
        return r;
    endfunction

    function automatic request_t random_request();
        request_t           r;
        int                 pick;
        logic [COORD_W-1:0] bx, by;
        pick = $urandom_range(0, 99);
        if (pick < 2)
        begin
            r     = blank_request(CMD_NONE);
            r.idx = 16'($urandom);
            r.val = $urandom;
            return r;
        end
        if (pick < 30)
        begin
            r     = blank_request(($urandom_range(0, 1) == 0) ? CMD_WRITE_A : CMD_WRITE_B);
            r.idx = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 700)) : 16'($urandom);
            r.val = ($urandom_range(0, 3) == 0) ? $urandom : ($urandom & $urandom & $urandom);
            return r;
        end
        r  = blank_request(CMD_TEST);
        bx = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
        by = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
        if ($urandom_range(0, 9) == 0)
        begin
            r.la = 16'($urandom);
            r.ta = 16'($urandom);
            r.lb = 16'($urandom);
            r.tb = 16'($urandom);
        end
        else
        begin
            r.la = bx + 16'($urandom_range(0, 80));
            r.ta = by + 16'($urandom_range(0, 3));
            r.lb = bx + 16'($urandom_range(0, 80));
            r.tb = by + 16'($urandom_range(0, 3));
        end
        if (pitch_a == 33 && pitch_b == 33 && $urandom_range(0, 9) == 0)
        begin
            r.tb = r.ta;
            r.wa = 11'($urandom_range(0, MAX_SPAN));
            r.wb = 11'($urandom_range(0, MAX_SPAN));
            r.ha = 11'($urandom_range(0, 2));
            r.hb = 11'($urandom_range(0, 2));
        end
        else
        begin
            r.wa = 11'($urandom_range(0, 70));
            r.wb = 11'($urandom_range(0, 70));
            r.ha = 11'($urandom_range(0, 5));
            r.hb = 11'($urandom_range(0, 5));
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        if ($urandom_range(0, 99) < recv_stall)
            res_ready <= 1'b0;
        else
            res_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
        begin
            if (hit_expected.size() == 0)
            begin
                $error("hit: result with no request outstanding, actual %0b", hit);
                fails++;
            end
            else
            begin
                bit want;
                want = hit_expected.pop_front();
                if (hit !== want)
                begin
                    $error("hit: expected %0b, actual %0b", want, hit);
                    fails++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_valid && cmd_ready) || (cfg_valid && cfg_ready) ||
            (res_valid && res_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        request_t directed [$];
        request_t r;
        int       pitch_plan_a [N_PHASES];
        int       pitch_plan_b [N_PHASES];
        int       idle_plan [4];
        int       stall_plan [4];
        int       start;
        bit       paused;

        pitch_plan_a = '{33, 2, 63, 0, 1, 17, 2, 33};
        pitch_plan_b = '{33, 2, 63, 1, 0, 40, 63, 5};
        idle_plan    = '{0, 48, 0, 29};
        stall_plan   = '{0, 0, 48, 29};

        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        cmd_valid    = 1'b0;
        command      = '0;
        word_index   = '0;
        word_value   = '0;
        left_a       = '0;
        top_a        = '0;
        span_x_a     = '0;
        span_y_a     = '0;
        left_b       = '0;
        top_b        = '0;
        span_x_b     = '0;
        span_y_b     = '0;
        send_idle    = 0;
        recv_stall   = 0;
        pitch_a      = 33;
        pitch_b      = 33;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        r = blank_request(CMD_WRITE_A);
        r.val = 32'hFFFF_FFFF;
        directed.push_back(r);
        r.cmd = CMD_WRITE_B;
        directed.push_back(r);
        directed.push_back(test_request(0, 0, 1, 1, 0, 0, 1, 1, 1));
        directed.push_back(test_request(0, 0, 0, 5, 0, 0, 5, 5, 0));
        directed.push_back(test_request(0, 0, 5, 5, 0, 0, 5, 0, 0));
        directed.push_back(test_request(-32768, -32768, 1024, 1024,
                                        32767, 32767, 1024, 1024, 0));
        directed.push_back(test_request(0, 0, 10, 10, 10, 0, 10, 10, 0));
        r = blank_request(CMD_NONE);
        r.idx = 16'hFFFF;
        r.val = 32'hFFFF_FFFF;
        directed.push_back(r);
        r = blank_request(CMD_WRITE_A);
        r.idx = 16'hFFFF;
        r.val = 32'h8000_0001;
        directed.push_back(r);
        r.cmd = CMD_WRITE_B;
        r.val = 32'h0000_0001;
        directed.push_back(r);
        directed.push_back(test_request(0, 0, 1024, 2, 0, 0, 1024, 2, -1));
        directed.push_back(test_request(0, 0, 40, 3, 5, 0, 40, 3, -1));
        directed.push_back(test_request(-32768, 32767, 64, 1, -32760, 32767, 64, 1, -1));
        directed.push_back(test_request(37, 3, 50, 6, 2, 1, 90, 9, -1));
        directed.push_back(test_request(1, 20, 33, 30, 0, 2, 33, 30, -1));
        directed.push_back(test_request(32767, 0, 1, 1, 32767, 0, 1, 1, -1));
        foreach (directed[i])
        begin
            cover_reads(directed[i]);
            send_request(directed[i]);
        end
        drain_results();

        for (int p = 0; p < N_PHASES; p++)
        begin
            write_pitch(REG_PITCH_A, PITCH_W'(pitch_plan_a[p]));
            write_pitch(REG_PITCH_B, PITCH_W'(pitch_plan_b[p]));
            send_idle  = idle_plan[p % 4];
            recv_stall = stall_plan[p % 4];
            start      = sent;
            paused     = 1'b0;
            while (sent - start < PER_PHASE)
            begin
                if (p == 2 && !paused && sent - start >= PER_PHASE / 2)
                begin
                    paused = 1'b1;
                    cmd_valid <= 1'b0;
                    @(posedge clk);
                    while (hit_expected.size() != 0)
                        @(posedge clk);
                end
                r = random_request();
                cover_reads(r);
                send_request(r);
            end
            drain_results();
        end

        if (fails == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire

>>> bitmask_overlap_collision.f
+incdir+hw/rtl
hw/rtl/boc_pkg.sv
hw/rtl/boc_ram.sv
hw/rtl/boc_front.sv
hw/rtl/boc_queue.sv
hw/rtl/boc_back.sv
hw/rtl/bitmask_overlap_collision.sv
hw/rtl/boc_checker.sv
tb/testbench.sv
